>>> rtl/bitmap_first_fit_block_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// bitmap first-fit allocator assertion macros
// shared concurrent assertion forms used by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// property that must hold at every edge outside reset
`define BFFA_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define BFFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// types and fixed constants of the bitmap first-fit block allocator
// ----------------------------------------------------------------------------
package bffa_pkg;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// operand widths of the block split, fixed by the request fields
	localparam int DIVD_W = 17;
	localparam int REM_W  = 14;

	// map bits examined per scan cycle
	localparam int SCAN_BITS = 8;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_BADSIZE = 2'd2,
		ST_BADFREE = 2'd3
	} alloc_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_CHECK,
		S_SWEEP,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic        cmd;
		logic [15:0] request_bytes;
		logic [13:0] free_offset;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [13:0] user_offset;
		logic [8:0]  blocks_in_use;
		logic [31:0] alloc_total;
		logic [31:0] alloc_failures;
	} rsp_item_t;

	typedef struct packed {
		logic          load;
		logic          scan_step;
		logic          rd_len;
		logic          free_commit;
		logic          sweep_step;
		logic          out_load;
		alloc_status_t out_status;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_free;
		logic size_bad;
		logic free_addr_bad;
		logic free_run_bad;
		logic scan_hit;
		logic scan_last;
		logic sweep_last;
		logic out_busy;
	} ctl_stat_t;

endpackage

>>> rtl/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// sequencer: decode, search or check, map sweep, result hand-off
// ----------------------------------------------------------------------------
module bffa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  bffa_pkg::ctl_stat_t stat,
	output bffa_pkg::ctl_cmd_t  cmd
);
	import bffa_pkg::*;

	ctrl_state_t   state_q, state_d;
	alloc_status_t res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		res_d          = res_q;
		cmd            = '0;
		cmd.out_status = res_q;
		req_stall      = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!stat.is_free) begin
					if (stat.size_bad) begin
						res_d   = ST_BADSIZE;
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end else if (stat.free_addr_bad) begin
					res_d   = ST_BADFREE;
					state_d = S_DONE;
				end else begin
					cmd.rd_len = 1'b1;
					state_d    = S_CHECK;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_hit) begin
					res_d   = ST_OK;
					state_d = S_SWEEP;
				end else if (stat.scan_last) begin
					res_d   = ST_NOFIT;
					state_d = S_DONE;
				end
			end
			S_CHECK: begin
				if (stat.free_run_bad) begin
					res_d   = ST_BADFREE;
					state_d = S_DONE;
				end else begin
					cmd.free_commit = 1'b1;
					res_d           = ST_OK;
					state_d         = S_SWEEP;
				end
			end
			S_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/bffa_dp.sv
// ----------------------------------------------------------------------------
// bffa_dp
// used map, start marks, length memory, block split, counters, result reg
// ----------------------------------------------------------------------------
`include "bitmap_first_fit_block_allocator_core_assert.svh"

module bffa_dp #(
	parameter int BLOCK_COUNT   = 256,
	parameter int BLOCK_BYTES   = 64,
	parameter int HEADER_BYTES  = 8,
	parameter int MAP_WORD_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bffa_pkg::req_item_t req_data,
	input  logic                rsp_stall,
	output logic                rsp_valid,
	output bffa_pkg::rsp_item_t rsp_data,
	input  bffa_pkg::ctl_cmd_t  cmd,
	output bffa_pkg::ctl_stat_t stat
);
	import bffa_pkg::*;

	localparam int IW   = $clog2(BLOCK_COUNT);
	localparam int CW   = $clog2(BLOCK_COUNT + 1);
	localparam int AW   = IW + 2;
	localparam int NCH  = (BLOCK_COUNT + SCAN_BITS - 1) / SCAN_BITS;
	localparam int CPW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int SW   = (BLOCK_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WPW  = (SW > 1) ? $clog2(SW) : 1;
	localparam int BSH  = $clog2(BLOCK_BYTES);

	// control and operand registers
	logic              is_free_q, req_zero_q, off_low_q;
	logic [DIVD_W-1:0] quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [CPW-1:0]    cp_q;
	logic [CW-1:0]     run_q;
	logic [WPW-1:0]    wp_q;
	logic [IW-1:0]     sw_start_q;
	logic [CW-1:0]     sw_len_q;
	logic [CW-1:0]     len_rd_q;
	logic [CW-1:0]     used_q;
	logic [31:0]       succ_q, fail_q;
	logic              out_valid_q;
	rsp_item_t         out_q;

	logic [BLOCK_COUNT-1:0] map_q, map_d;
	logic [BLOCK_COUNT-1:0] mark_q;
	logic [CW-1:0]          len_mem [BLOCK_COUNT];

	logic [DIVD_W-1:0] dividend;
	logic [IW-1:0]     idx;
	logic [CW-1:0]     need;
	logic              hit;
	logic [IW-1:0]     hit_start;
	logic [CW-1:0]     run_d;
	logic              fail_inc;

	assign dividend = req_data.cmd == CMD_FREE
		? DIVD_W'(req_data.free_offset) - DIVD_W'(HEADER_BYTES)
		: DIVD_W'(req_data.request_bytes) + DIVD_W'(HEADER_BYTES + BLOCK_BYTES - 1);

	assign idx  = quo_q[IW-1:0];
	assign need = quo_q[CW-1:0];

	assign fail_inc = !is_free_q && cmd.out_status != ST_OK;

	// first-fit scan over one chunk of the map
	always_comb begin
		logic [AW-1:0] b;
		logic          u;
		hit       = 1'b0;
		hit_start = '0;
		run_d     = run_q;
		for (int k = 0; k < SCAN_BITS; k++) begin
			b = AW'(cp_q) * AW'(SCAN_BITS) + AW'(k);
			u = (b >= AW'(BLOCK_COUNT)) ? 1'b1 : map_q[b[IW-1:0]];
			run_d = u ? '0 : run_d + 1'b1;
			if (!hit && !u && run_d >= need) begin
				hit       = 1'b1;
				hit_start = IW'(b + 1'b1 - AW'(need));
			end
		end
	end

	// sweep one map word, setting or clearing the bits of the run
	always_comb begin
		logic [AW-1:0] b;
		map_d = map_q;
		for (int j = 0; j < MAP_WORD_BITS; j++) begin
			b = AW'(wp_q) * AW'(MAP_WORD_BITS) + AW'(j);
			if (b < AW'(BLOCK_COUNT) && b >= AW'(sw_start_q)
					&& b < AW'(sw_start_q) + AW'(sw_len_q)) begin
				map_d[b[IW-1:0]] = !is_free_q;
			end
		end
	end

	always_comb begin
		stat               = '0;
		stat.is_free       = is_free_q;
		stat.size_bad      = req_zero_q || quo_q == '0
			|| quo_q > DIVD_W'(BLOCK_COUNT);
		stat.free_addr_bad = off_low_q || rem_q != '0
			|| quo_q >= DIVD_W'(BLOCK_COUNT);
		stat.free_run_bad  = !map_q[idx] || !mark_q[idx] || len_rd_q == '0
			|| AW'(len_rd_q) > AW'(BLOCK_COUNT) - AW'(idx);
		stat.scan_hit      = hit;
		stat.scan_last     = cp_q == CPW'(NCH - 1);
		stat.sweep_last    = wp_q == WPW'(SW - 1);
		stat.out_busy      = out_valid_q && rsp_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && hit) begin
			len_mem[hit_start] <= need;
		end
		if (cmd.rd_len) begin
			len_rd_q <= len_mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_free_q  <= req_data.cmd;
			req_zero_q <= req_data.request_bytes == '0;
			off_low_q  <= req_data.free_offset < 14'(HEADER_BYTES);
			// block size is a power of two: split by shift and mask
			quo_q      <= dividend >> BSH;
			rem_q      <= REM_W'(dividend & DIVD_W'(BLOCK_BYTES - 1));
			cp_q       <= '0;
			run_q      <= '0;
			wp_q       <= '0;
		end
		if (cmd.scan_step) begin
			cp_q  <= cp_q + 1'b1;
			run_q <= run_d;
			if (hit) begin
				sw_start_q <= hit_start;
				sw_len_q   <= need;
			end
		end
		if (cmd.free_commit) begin
			sw_start_q <= idx;
			sw_len_q   <= len_rd_q;
		end
		if (cmd.sweep_step) begin
			wp_q <= wp_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_q.status      <= cmd.out_status;
			out_q.user_offset <= (!is_free_q && cmd.out_status == ST_OK)
				? 14'(32'(sw_start_q) * 32'(BLOCK_BYTES) + 32'(HEADER_BYTES)) : '0;
			out_q.alloc_total    <= succ_q;
			out_q.alloc_failures <= fail_q + 32'(fail_inc);
			out_q.blocks_in_use  <= 9'(32'(used_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q       <= '0;
			mark_q      <= '0;
			used_q      <= '0;
			succ_q      <= '0;
			fail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep_step) begin
				map_q <= map_d;
			end
			if (cmd.scan_step && hit) begin
				mark_q[hit_start] <= 1'b1;
			end
			if (cmd.free_commit) begin
				mark_q[idx] <= 1'b0;
			end
			// counters move at the sweep end, so the result register sees them next
			if (cmd.sweep_step && stat.sweep_last) begin
				if (!is_free_q) begin
					used_q <= used_q + sw_len_q;
					succ_q <= succ_q + 1'b1;
				end else if (used_q >= sw_len_q) begin
					used_q <= used_q - sw_len_q;
				end
			end
			if (cmd.out_load && fail_inc) begin
				fail_q <= fail_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		rsp_data = out_q;
		if (cmd.out_load) begin
			rsp_data = out_q;
		end
	end

	assign rsp_valid = out_valid_q;

	`BFFA_ASSERT_ALWAYS(a_used_bound, clk, arst_n, used_q <= CW'(BLOCK_COUNT), "used past pool")
	`BFFA_ASSERT_IMPLY(a_commit_free, clk, arst_n, cmd.free_commit, is_free_q, "commit on alloc")
	`BFFA_ASSERT_IMPLY(a_scan_alloc, clk, arst_n, cmd.scan_step, !is_free_q, "scan on a free")
	`BFFA_ASSERT_IMPLY(a_load_clear, clk, arst_n, cmd.out_load, !(out_valid_q && rsp_stall), "result overwritten")

endmodule

>>> rtl/bitmap_first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_core
// first-fit contiguous block allocator over a used-bit map
// ----------------------------------------------------------------------------
// request channel req_*: cmd 0 allocates request_bytes, cmd 1 frees the user
// offset in free_offset. one request is worked at a time; req_stall stays
// high from acceptance until the result is parked in the response register.
// response channel rsp_*: one transaction per request with status, granted
// offset and the usage and allocation counters after the request.
// sequence: at acceptance the size or offset is split by the block size (a power
//   of two) with a shift and a mask, a decode step checks it, then
//   allocate: a scan of up to ceil(BLOCK_COUNT/8) map chunks (8 map bits a cycle),
//   a sweep over ceil(BLOCK_COUNT/MAP_WORD_BITS) map words, the result step
//   free: a length check, the same sweep, the result step
//   rejected requests skip to the result step
// the next request can be taken in the cycle after the result is loaded.
// a new request is taken while the previous result still waits; a result
// completes only once the receiver has taken the one before.
// reset clears the used map, start marks and counters at once; the run
// length memory needs no clearing: its value counts only under a start mark.
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator_core #(
	parameter int BLOCK_COUNT   = 256,
	parameter int BLOCK_BYTES   = 64,
	parameter int HEADER_BYTES  = 8,
	parameter int MAP_WORD_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  bffa_pkg::req_item_t req_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bffa_pkg::rsp_item_t rsp_data
);
	import bffa_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	bffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bffa_dp #(
		.BLOCK_COUNT   (BLOCK_COUNT),
		.BLOCK_BYTES   (BLOCK_BYTES),
		.HEADER_BYTES  (HEADER_BYTES),
		.MAP_WORD_BITS (MAP_WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
